### hw/rtl/blns_pkg.sv
// Shared types, constants and helpers for the bicubic lattice noise sampler.
// No dependencies; used by blns_ctrl, blns_datapath and the top level.
package blns_pkg;

    localparam int MAX_SIDE = 64;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SIDE_W   = 7;
    localparam int COORD_W  = 6;
    localparam int PW       = 28;        // operand width of a cubic (row results)
    localparam int XW       = 52;        // wide intermediate width
    localparam int XL       = XW / 2;    // split point of the multiplicand
    localparam int PRW      = XW + 17;   // product width
    localparam int NOISE_W  = 18;

    localparam logic [3:0] PH_ABC = 4'd0;
    localparam logic [3:0] PH_M0A = 4'd1;
    localparam logic [3:0] PH_M1A = 4'd2;
    localparam logic [3:0] PH_U   = 4'd3;
    localparam logic [3:0] PH_M0B = 4'd4;
    localparam logic [3:0] PH_M1B = 4'd5;
    localparam logic [3:0] PH_W   = 4'd6;
    localparam logic [3:0] PH_M0C = 4'd7;
    localparam logic [3:0] PH_M1C = 4'd8;
    localparam logic [3:0] PH_FIN = 4'd9;

    localparam logic [2:0] COL_PASS = 3'd4;
    localparam logic [4:0] FETCH_LAST = 5'd16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_CALC  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    typedef struct packed {
        logic       load;      // capture item fields
        logic       wr;        // write lattice entry
        logic       rd;        // issue a lattice read
        logic [3:0] rd_k;      // neighbourhood position of that read
        logic       cap;       // shift read data into the window
        logic       calc;      // run one cubic step
        logic [3:0] phase;
        logic       col;       // column pass (over row results)
        logic       out_load;  // load the output register
    } t_cmd;

    // Clamp anchor + ofs - 1 into 0..side-1.
    function automatic logic [COORD_W-1:0] clamp_ofs(input logic [COORD_W-1:0] anchor,
                                                     input logic [1:0] ofs,
                                                     input logic [SIDE_W-1:0] side);
        logic [7:0] v;
        logic [7:0] s8;
        v  = {2'b00, anchor} + {6'b0, ofs};
        s8 = {1'b0, side};
        if (v == 8'd0) begin
            clamp_ofs = '0;
        end else if ((v - 8'd1) >= s8) begin
            clamp_ofs = COORD_W'(s8 - 8'd1);
        end else begin
            clamp_ofs = COORD_W'(v - 8'd1);
        end
    endfunction

endpackage

### hw/rtl/blns_ctrl.sv
// Controller FSM of the lattice noise sampler: handshakes and step sequencing.
// Depends on blns_pkg; drives blns_datapath through a t_cmd struct.
module blns_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_operation,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output blns_pkg::t_cmd o_cmd
);

    blns_pkg::t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [2:0] r_pass, n_pass;
    logic [3:0] r_phase, n_phase;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == blns_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.rd_k  = r_cnt[3:0];
        o_cmd.phase = r_phase;
        o_cmd.col   = (r_pass == blns_pkg::COL_PASS);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            blns_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_operation == blns_pkg::OP_WRITE) begin
                        o_cmd.wr = 1'b1;
                        n_state  = blns_pkg::S_DONE;
                    end else begin
                        n_cnt   = '0;
                        n_state = blns_pkg::S_FETCH;
                    end
                end
            end
            blns_pkg::S_FETCH: begin
                o_cmd.rd  = (r_cnt != blns_pkg::FETCH_LAST);
                o_cmd.cap = (r_cnt != 5'd0);
                n_cnt     = r_cnt + 5'd1;
                if (r_cnt == blns_pkg::FETCH_LAST) begin
                    n_pass  = '0;
                    n_phase = blns_pkg::PH_ABC;
                    n_state = blns_pkg::S_CALC;
                end
            end
            blns_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
                if (r_phase == blns_pkg::PH_FIN) begin
                    n_phase = blns_pkg::PH_ABC;
                    if (r_pass == blns_pkg::COL_PASS) begin
                        n_state = blns_pkg::S_DONE;
                    end else begin
                        n_pass = r_pass + 3'd1;
                    end
                end else begin
                    n_phase = r_phase + 4'd1;
                end
            end
            blns_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = blns_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = blns_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blns_pkg::S_IDLE;
            r_cnt       <= '0;
            r_pass      <= '0;
            r_phase     <= blns_pkg::PH_ABC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hw/rtl/blns_datapath.sv
// Datapath of the lattice noise sampler: lattice memory, 4x4 window,
// shared cubic unit with a two-step multiplier, output register. Uses blns_pkg.
module blns_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [blns_pkg::SIDE_W-1:0]         i_cfg_data,
    input  blns_pkg::t_cmd                      i_cmd,
    input  logic                                i_operation,
    input  logic [11:0]                         i_entry_index,
    input  logic signed [15:0]                  i_entry_value,
    input  logic [5:0]                          i_anchor_row,
    input  logic [5:0]                          i_anchor_col,
    input  logic [15:0]                         i_frac_x,
    input  logic [15:0]                         i_frac_y,
    output logic signed [blns_pkg::NOISE_W-1:0] o_noise_value,
    output logic                                o_is_sample
);

    localparam int XW  = blns_pkg::XW;
    localparam int XL  = blns_pkg::XL;
    localparam int PW  = blns_pkg::PW;
    localparam int PRW = blns_pkg::PRW;
    localparam int CW  = blns_pkg::COORD_W;

    logic [15:0]                  r_mem [blns_pkg::DEPTH];
    logic [15:0]                  r_mem_q;
    logic [blns_pkg::SIDE_W-1:0]  r_side;
    logic [blns_pkg::SIDE_W-1:0]  r_side_c;
    logic [CW-1:0]                r_arow, r_acol;
    logic [15:0]                  r_tx, r_ty;
    logic                         r_is_sample;
    logic [15:0]                  r_lat [16];
    logic signed [PW-1:0]         r_rows [4];
    logic signed [XW-1:0]         r_a, r_b, r_x;
    logic signed [PRW-1:0]        r_prod;
    logic signed [blns_pkg::NOISE_W-1:0] r_res;
    logic signed [blns_pkg::NOISE_W-1:0] r_noise;
    logic                         r_out_sample;

    logic [blns_pkg::SIDE_W-1:0]  side_in;
    logic [CW-1:0]                arow_in, acol_in, row_sel, col_sel;
    logic [blns_pkg::ADDR_W-1:0]  addr_full;
    logic signed [XW-1:0]         p [4];
    logic signed [XW-1:0]         ca, cb, cc, fin_s, col_r;
    logic [15:0]                  t;
    logic signed [16:0]           t_s;
    logic [41:0]                  mul_lo;
    logic signed [42:0]           mul_hi;
    logic signed [XW-25:0]        col_v;

    // side clamp: 0 acts as 1, above the maximum as the maximum
    always_comb begin
        if (r_side == '0) begin
            side_in = 7'd1;
        end else if (r_side > 7'(blns_pkg::MAX_SIDE)) begin
            side_in = 7'(blns_pkg::MAX_SIDE);
        end else begin
            side_in = r_side;
        end
        arow_in = ({1'b0, i_anchor_row} >= side_in) ? CW'(side_in - 7'd1) : i_anchor_row;
        acol_in = ({1'b0, i_anchor_col} >= side_in) ? CW'(side_in - 7'd1) : i_anchor_col;
        row_sel = blns_pkg::clamp_ofs(r_arow, i_cmd.rd_k[3:2], r_side_c);
        col_sel = blns_pkg::clamp_ofs(r_acol, i_cmd.rd_k[1:0], r_side_c);
        addr_full = blns_pkg::ADDR_W'(row_sel) * blns_pkg::ADDR_W'(r_side_c)
                  + blns_pkg::ADDR_W'(col_sel);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_entry_index] <= i_entry_value;
        end
        if (i_cmd.rd) begin
            r_mem_q <= r_mem[addr_full];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= 7'(blns_pkg::MAX_SIDE);
        end else if (i_cfg_we) begin
            r_side <= i_cfg_data;
        end
    end

    // cubic operands: window head row, or the four row results
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_cmd.col) begin
                p[k] = XW'(r_rows[k]);
            end else begin
                p[k] = XW'($signed(r_lat[k]));
            end
        end
        ca = p[2] - p[0];
        cb = (p[0] <<< 1) - (p[1] <<< 2) - p[1] + (p[2] <<< 2) - p[3];
        cc = (p[1] <<< 1) + p[1] - (p[2] <<< 1) - p[2] + p[3] - p[0];
        t      = i_cmd.col ? r_ty : r_tx;
        t_s    = $signed({1'b0, t});
        mul_lo = t * r_x[XL-1:0];
        mul_hi = t_s * $signed(r_x[XW-1:XL]);
        fin_s  = (p[1] <<< 16) + XW'(r_prod >>> 17);
        col_r  = (fin_s + (XW'(1) <<< 23)) >>> 24;
        col_v  = col_r[XW-25:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_sample <= i_operation;
            r_side_c    <= side_in;
            r_arow      <= arow_in;
            r_acol      <= acol_in;
            r_tx        <= i_frac_x;
            r_ty        <= i_frac_y;
        end
        if (i_cmd.cap) begin
            for (int i = 0; i < 15; i++) begin
                r_lat[i] <= r_lat[i+1];
            end
            r_lat[15] <= r_mem_q;
        end
        if (i_cmd.calc) begin
            case (i_cmd.phase)
                blns_pkg::PH_ABC: begin
                    r_a <= ca;
                    r_b <= cb;
                    r_x <= cc;
                end
                blns_pkg::PH_M0A, blns_pkg::PH_M0B, blns_pkg::PH_M0C: begin
                    r_prod <= PRW'($signed({1'b0, mul_lo}));
                end
                blns_pkg::PH_M1A, blns_pkg::PH_M1B, blns_pkg::PH_M1C: begin
                    r_prod <= r_prod + (PRW'(mul_hi) <<< XL);
                end
                blns_pkg::PH_U: begin
                    r_x <= (r_b <<< 16) + r_prod[XW-1:0];
                end
                blns_pkg::PH_W: begin
                    r_x <= (r_a <<< 16) + XW'(r_prod >>> 16);
                end
                blns_pkg::PH_FIN: begin
                    if (i_cmd.col) begin
                        if (col_v > (XW-24)'(131071)) begin
                            r_res <= 18'sd131071;
                        end else if (col_v < -(XW-24)'(131072)) begin
                            r_res <= -18'sd131072;
                        end else begin
                            r_res <= col_v[blns_pkg::NOISE_W-1:0];
                        end
                    end else begin
                        for (int i = 0; i < 12; i++) begin
                            r_lat[i] <= r_lat[i+4];
                        end
                        for (int i = 0; i < 3; i++) begin
                            r_rows[i] <= r_rows[i+1];
                        end
                        r_rows[3] <= PW'(fin_s >>> 8);
                    end
                end
                default: begin
                    r_x <= r_x;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_sample <= r_is_sample;
            r_noise      <= r_is_sample ? r_res : '0;
        end
    end

    assign o_noise_value = r_noise;
    assign o_is_sample   = r_out_sample;

endmodule

### hw/rtl/bicubic_lattice_noise_sampler.sv
// Top level of the bicubic lattice noise sampler.
// Depends on blns_pkg, blns_ctrl and blns_datapath.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one item per transfer.
//    operation 0 writes entry_value at entry_index into the 64x64 lattice;
//    operation 1 samples at (anchor_row, anchor_col) with offsets frac_x/y.
//  - Output channel (o_out_valid / i_out_ready) returns exactly one result
//    per item: noise_value (Q2.15, zero for writes) and is_sample.
//  - i_cfg_we / i_cfg_data write lattice_side; do it only while idle.
//  - Steps: a write goes from the transfer to the output register load; a
//    sample first does the sixteen reads of the single-port lattice memory,
//    then five cubics (four rows, one column) at ten steps each on the one
//    shared cubic unit, then loads the output register. The next item is
//    taken in the cycle after the result is loaded, so no new item is taken
//    while one is still in progress.
//  - The output register holds a finished result while the next item is
//    accepted; if the receiver stalls, the following result waits inside.
//  - Reset (i_rst_n low, synchronous) clears control and sets lattice_side
//    to 64; lattice contents are undefined until written.
module bicubic_lattice_noise_sampler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [11:0]        i_entry_index,
    input  logic signed [15:0] i_entry_value,
    input  logic [5:0]         i_anchor_row,
    input  logic [5:0]         i_anchor_col,
    input  logic [15:0]        i_frac_x,
    input  logic [15:0]        i_frac_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_noise_value,
    output logic               o_is_sample
);

    blns_pkg::t_cmd cmd;

    blns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    blns_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_operation   (i_operation),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_anchor_row  (i_anchor_row),
        .i_anchor_col  (i_anchor_col),
        .i_frac_x      (i_frac_x),
        .i_frac_y      (i_frac_y),
        .o_noise_value (o_noise_value),
        .o_is_sample   (o_is_sample)
    );

endmodule

### test/blns_checker.sv
// Checker for the bicubic lattice noise sampler: watches both channels and the config port,
// predicts each result with its own lattice copy and compares. Depends on blns_pkg.
`timescale 1ns / 100ps

module blns_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_operation,
    input  logic [11:0]        i_entry_index,
    input  logic signed [15:0] i_entry_value,
    input  logic [5:0]         i_anchor_row,
    input  logic [5:0]         i_anchor_col,
    input  logic [15:0]        i_frac_x,
    input  logic [15:0]        i_frac_y,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [17:0] i_noise_value,
    input  logic               i_is_sample,
    output int                 o_fail_count,
    output int                 o_pending
);
    import blns_pkg::*;

    typedef struct packed {
        logic signed [17:0] noise;
        logic               smp;
    } t_noise_res;

    logic signed [15:0] lattice_copy [DEPTH];
    logic [6:0]         side_reg;
    t_noise_res         noise_fifo [$];

    assign o_pending = noise_fifo.size();

    // floor division by 2^n of a signed value (arithmetic shift floors)
    function automatic longint fshr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint catmull(input longint p0, input longint p1,
                                       input longint p2, input longint p3, input longint t);
        longint a, b, c, u, w;
        a = p2 - p0;
        b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c = 3 * (p1 - p2) + p3 - p0;
        u = b * 65536 + t * c;
        w = a * 65536 + fshr(t * u, 16);
        return p1 * 65536 + fshr(t * w, 17);
    endfunction

    function automatic int clip(input int v, input int sd);
        if (v < 0) return 0;
        if (v >= sd) return sd - 1;
        return v;
    endfunction

    function automatic logic signed [17:0] bicubic_noise(input int arow, input int acol,
                                                         input longint tx, input longint ty);
        int sd, rr, cc;
        longint p [4];
        longint rows [4];
        longint res;
        sd = side_reg;
        if (sd < 1) sd = 1;
        if (sd > MAX_SIDE) sd = MAX_SIDE;
        if (arow >= sd) arow = sd - 1;
        if (acol >= sd) acol = sd - 1;
        for (int r = 0; r < 4; r++) begin
            rr = clip(arow + r - 1, sd);
            for (int k = 0; k < 4; k++) begin
                cc = clip(acol + k - 1, sd);
                p[k] = lattice_copy[rr * sd + cc];
            end
            rows[r] = fshr(catmull(p[0], p[1], p[2], p[3], tx), 8);
        end
        res = fshr(catmull(rows[0], rows[1], rows[2], rows[3], ty) + (64'sd1 <<< 23), 24);
        if (res > 131071) res = 131071;
        if (res < -131072) res = -131072;
        return res[17:0];
    endfunction

    always @(posedge i_clk) begin
        t_noise_res exp_res;
        if (!i_rst_n) begin
            side_reg     <= 7'd64;
            o_fail_count <= 0;
            noise_fifo.delete();
        end else begin
            if (i_cfg_we) side_reg <= i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                if (i_operation == OP_WRITE) begin
                    lattice_copy[i_entry_index] = i_entry_value;
                    noise_fifo.push_back('{noise: '0, smp: 1'b0});
                end else begin
                    noise_fifo.push_back('{noise: bicubic_noise(i_anchor_row, i_anchor_col,
                                                                i_frac_x, i_frac_y),
                                           smp: 1'b1});
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (noise_fifo.size() == 0) begin
                    $display("%0t: unexpected result noise=%0d is_sample=%0b",
                             $time, i_noise_value, i_is_sample);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_res = noise_fifo.pop_front();
                    if (exp_res.noise !== i_noise_value || exp_res.smp !== i_is_sample) begin
                        $display("%0t: mismatch exp noise=%0d smp=%0b got noise=%0d smp=%0b",
                                 $time, exp_res.noise, exp_res.smp, i_noise_value,
                                 i_is_sample);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### test/tb_bicubic_lattice_noise_sampler.sv
// Testbench top for the bicubic lattice noise sampler: stimulus, config phases, verdict.
// Depends on blns_pkg, blns_checker and the sampler RTL.
`timescale 1ns / 100ps

module tb_bicubic_lattice_noise_sampler;
    import blns_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [6:0]         cfg_data;
    logic               in_valid, in_ready;
    logic               operation;
    logic [11:0]        entry_index;
    logic signed [15:0] entry_value;
    logic [5:0]         anchor_row, anchor_col;
    logic [15:0]        frac_x, frac_y;
    logic               out_valid, out_ready;
    logic signed [17:0] noise_value;
    logic               is_sample;
    int                 fail_count, pending;
    bit                 hold_off;    // forces a long receiver stall
    bit                 stim_done;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    bicubic_lattice_noise_sampler u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_operation(operation),
        .i_entry_index(entry_index), .i_entry_value(entry_value),
        .i_anchor_row(anchor_row), .i_anchor_col(anchor_col),
        .i_frac_x(frac_x), .i_frac_y(frac_y),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_noise_value(noise_value), .o_is_sample(is_sample)
    );

    blns_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_operation(operation),
        .i_entry_index(entry_index), .i_entry_value(entry_value),
        .i_anchor_row(anchor_row), .i_anchor_col(anchor_col),
        .i_frac_x(frac_x), .i_frac_y(frac_y),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_noise_value(noise_value), .i_is_sample(is_sample),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int g;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 1'b0;
                for (int i = 0; i < 600; i++) @(posedge clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g == 0) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b0;
                repeat (g - 1) @(posedge clk);
            end
        end
    end

    // one transfer; valid stays up with a fixed payload until accepted,
    // and is dropped by the next gap or by drain
    task automatic send_item(input logic op, input logic [11:0] idx, input logic [15:0] val,
                             input logic [5:0] ar, input logic [5:0] ac,
                             input logic [15:0] fx, input logic [15:0] fy, input bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        repeat (g) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        entry_index <= idx;
        entry_value <= val;
        anchor_row  <= ar;
        anchor_col  <= ac;
        frac_x      <= fx;
        frac_y      <= fy;
        do @(posedge clk); while (!in_ready);
    endtask

    // waits until every expected result has come back, then lets the block settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_side(input logic [6:0] sd);
        cfg_we   <= 1'b1;
        cfg_data <= sd;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // fills every entry a sample at this side can reach (side 0 reads entry 0)
    task automatic fill_lattice(input int sd, input bit extreme);
        int n;
        logic [15:0] v;
        n = (sd < 1) ? 1 : ((sd > MAX_SIDE) ? MAX_SIDE : sd);
        for (int i = 0; i < n * n; i++) begin
            if (extreme) v = (i % 2) ? 16'h7FFF : 16'h8000;
            else v = 16'($urandom());
            send_item(OP_WRITE, i[11:0], v, 6'($urandom()), 6'($urandom()),
                      16'($urandom()), 16'($urandom()), 1'b1);
        end
    endtask

    // at full side: rows 0..2 and 62..63, all a sample anchored on row 0 or 63 reads
    task automatic fill_edge_rows();
        int r;
        for (int j = 0; j < 5; j++) begin
            r = (j < 3) ? j : j + 59;
            for (int c = 0; c < MAX_SIDE; c++) begin
                send_item(OP_WRITE, 12'(r * MAX_SIDE + c), 16'($urandom()),
                          6'($urandom()), 6'($urandom()), 16'($urandom()),
                          16'($urandom()), 1'b1);
            end
        end
    endtask

    task automatic random_sample(input bit edge_rows);
        logic [15:0] fx, fy;
        logic [5:0]  ar;
        fx = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 16'hFFFF : 16'h0)
                                         : 16'($urandom());
        fy = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1)) ? 16'hFFFF : 16'h0)
                                         : 16'($urandom());
        ar = edge_rows ? (($urandom_range(0, 1) != 0) ? 6'd63 : 6'd0) : 6'($urandom());
        send_item(OP_SAMPLE, 12'($urandom()), 16'($urandom()), ar, 6'($urandom()),
                  fx, fy, 1'b0);
    endtask

    // random phase at one side: rewrites inside range plus samples
    task automatic random_phase(input int sd, input int count, input bit edge_rows);
        int n;
        n = (sd < 1) ? 1 : ((sd > MAX_SIDE) ? MAX_SIDE : sd);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                send_item(OP_WRITE, 12'($urandom_range(0, n * n - 1)), 16'($urandom()),
                          6'($urandom()), 6'($urandom()), 16'($urandom()),
                          16'($urandom()), 1'b0);
            end else begin
                random_sample(edge_rows);
            end
        end
    endtask

    initial begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_data    <= 7'd0;
        in_valid    <= 1'b0;
        operation   <= OP_WRITE;
        entry_index <= '0;
        entry_value <= '0;
        anchor_row  <= '0;
        anchor_col  <= '0;
        frac_x      <= '0;
        frac_y      <= '0;
        hold_off    = 1'b0;
        stim_done   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed at reset side 64: writes only, extreme values near the corners and edges
        for (int i = 0; i < 12; i++)
            send_item(OP_WRITE, 12'((i < 6) ? i : 4095 - (i - 6)),
                      (i % 2) ? 16'h7FFF : 16'h8000,
                      6'h3F, 6'h3F, 16'hFFFF, 16'hFFFF, 1'b0);
        for (int i = 0; i < 12; i++)
            send_item(OP_WRITE, 12'(64 + i), 16'h7FFF, 6'd0, 6'd0, 16'h0, 16'h0, 1'b0);
        drain();

        // side 4 with extreme values: saturation, clamping, anchors beyond side
        set_side(7'd4);
        fill_lattice(4, 1'b1);
        send_item(OP_SAMPLE, 12'hFFF, 16'hFFFF, 6'd0, 6'd0, 16'h0, 16'h0, 1'b0);
        send_item(OP_SAMPLE, 12'd0, 16'd0, 6'd3, 6'd3, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(OP_SAMPLE, 12'd0, 16'd0, 6'h3F, 6'h3F, 16'h8000, 16'h8000, 1'b0);
        send_item(OP_SAMPLE, 12'd0, 16'd0, 6'd0, 6'd3, 16'hFFFF, 16'h0, 1'b0);
        send_item(OP_SAMPLE, 12'd0, 16'd0, 6'd2, 6'd1, 16'h0001, 16'hFFFE, 1'b0);
        random_phase(4, 40, 1'b0);
        drain();

        // side 0 acts as 1, side 1
        set_side(7'd0);
        fill_lattice(1, 1'b0);
        random_phase(1, 20, 1'b0);
        drain();
        set_side(7'd1);
        random_phase(1, 20, 1'b0);
        drain();

        // side above the maximum clamps to 64; long receiver hold-off here
        set_side(7'd127);
        fill_edge_rows();
        hold_off = 1'b1;
        random_phase(64, 120, 1'b1);
        drain();

        // a mid size, then the largest legal one
        set_side(7'd7);
        fill_lattice(7, 1'b0);
        random_phase(7, 80, 1'b0);
        drain();
        set_side(7'd64);
        random_phase(64, 80, 1'b1);
        drain();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
